// ===== hw/rtl/iqr_pkg.sv =====
// Shared widths, command codes and controller/datapath interface types.
package iqr_pkg;

    localparam int CMD_W          = 3;
    localparam int INDEX_W        = 5;
    localparam int WORD_W         = 32;
    localparam int COUNT_W        = 6;
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the accepted command
        logic exec_write;  // push / write into the store
        logic exec_fetch;  // read the target entry
        logic reject;      // result is ok=0, no state change
        logic fetch_done;  // take fetched word, update head/count, start shift
        logic shift_step;  // one move of the removal shift
        logic load_out;    // load the result into the output register
    } iqr_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic legal;       // command can be carried out
        logic needs_fetch; // pop, read or remove
        logic is_remove;
        logic no_moves;    // removal closes without any shift
        logic last_move;   // current shift step is the final one
    } iqr_sts_t;

endpackage

// ===== hw/rtl/indexed_queue_with_removal_top.sv =====
// Top level of the indexed queue with removal: controller plus datapath.
//
// Usage:
//   Request channel (req_valid/req_stall) carries cmd, index and write_data;
//   a transfer happens on a clock edge with req_valid high and req_stall low.
//   Commands: push at tail, pop head, read at index, write at index, remove
//   at index. Each request yields exactly one response transfer on the
//   rsp_valid/rsp_stall channel with ok, read_data and count (entries held
//   after the command). Rejected commands (full, empty, index out of range,
//   unused codes) return ok=0, read_data=0 and leave the queue unchanged.
//   Push, write and rejects finish after the execute step, pop and read after
//   a fetch, and remove after a fetch and m shift moves, where m is the number of
//   entries shifted (at most DEPTH/2 - 1). The single read and single write
//   port of the entry store allows one entry move per cycle.
//   One request at a time: req_stall is high while a command is in progress,
//   so a request is taken only after the last result loads. A finished response
//   waits in the output register while a new request is taken. If the receiver
//   stalls with a response held, the next command finishes and waits to load.
//   Reset empties the queue (count 0, head 0) and clears rsp_valid; store
//   contents are not cleared and are never read before being written.
module indexed_queue_with_removal_top
    import iqr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [INDEX_W-1:0] index,
    input  logic [WORD_W-1:0]  write_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic               ok,
    output logic [WORD_W-1:0]  read_data,
    output logic [COUNT_W-1:0] count
);

    iqr_ctl_t ctl;
    iqr_sts_t sts;

    // sequencer: one command at a time, owns both handshakes
    iqr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // store, head/count state and response payload registers
    iqr_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cmd        (cmd),
        .index      (index),
        .write_data (write_data),
        .ok         (ok),
        .read_data  (read_data),
        .count      (count)
    );

endmodule

// ===== hw/rtl/iqr_datapath.sv =====
// Entry store, head/count registers, address arithmetic and result registers.
module iqr_datapath
    import iqr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  iqr_ctl_t           ctl,
    output iqr_sts_t           sts,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [INDEX_W-1:0] index,
    input  logic [WORD_W-1:0]  write_data,
    output logic               ok,
    output logic [WORD_W-1:0]  read_data,
    output logic [COUNT_W-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    cmd_t                  cmd_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic                  res_ok_reg;
    logic [DATA_WIDTH-1:0] res_data_reg;
    logic                  fwd_reg;
    logic [CW-1:0]         moves_reg;
    logic [CW-1:0]         dst_reg;
    logic                  ok_reg;
    logic [WORD_W-1:0]     read_data_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [DATA_WIDTH-1:0] wdata_in;
    logic [WORD_W-1:0]     rdata_word;
    logic [COUNT_W-1:0]    count_word;

    logic [LW-1:0]         idx_l, cnt_l;
    logic [CW-1:0]         idx_c, n_after;
    logic                  fwd_calc;
    logic [CW-1:0]         moves_calc;
    logic [CW-1:0]         tgt_pos, first_src, next_src;
    logic [AW-1:0]         tgt_slot, dst_slot, first_src_slot, next_src_slot, head_inc;
    logic                  legal;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    // physical slot of a logical position (position below DEPTH)
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    // port word <-> stored word, and count to port width
    for (genvar b = 0; b < DATA_WIDTH; b++)
    begin : g_win
        if (b < WORD_W)
        begin : g_bit
            assign wdata_in[b] = write_data[b];
        end
        else
        begin : g_zero
            assign wdata_in[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < WORD_W; b++)
    begin : g_rout
        if (b < DATA_WIDTH)
        begin : g_bit
            assign rdata_word[b] = res_data_reg[b];
        end
        else
        begin : g_zero
            assign rdata_word[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < COUNT_W; b++)
    begin : g_cout
        if (b < CW)
        begin : g_bit
            assign count_word[b] = cnt_reg[b];
        end
        else
        begin : g_zero
            assign count_word[b] = 1'b0;
        end
    end

    // decode and range checks
    assign idx_l   = LW'(idx_reg);
    assign cnt_l   = LW'(cnt_reg);
    assign idx_c   = idx_l[CW-1:0];
    assign n_after = cnt_reg - CW'(1);

    always_comb
    begin
        legal   = 1'b0;
        tgt_pos = idx_c;
        unique case (cmd_reg)
            CMD_PUSH:
            begin
                legal   = (cnt_reg < DEPTH_C);
                tgt_pos = cnt_reg;
            end
            CMD_POP:
            begin
                legal   = (cnt_reg != '0);
                tgt_pos = '0;
            end
            CMD_READ, CMD_WRITE, CMD_REMOVE:
            begin
                legal = (idx_l < cnt_l);
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    // removal: close the gap from the nearer end
    assign fwd_calc   = ({idx_c, 1'b0} >= {1'b0, n_after});
    assign moves_calc = fwd_calc ? (n_after - idx_c) : idx_c;
    assign first_src  = fwd_calc ? (idx_c + CW'(1)) : (idx_c - CW'(1));
    assign next_src   = fwd_reg ? (dst_reg + CW'(2)) : (dst_reg - CW'(2));

    assign tgt_slot       = slot_of(head_reg, AW'(tgt_pos));
    assign dst_slot       = slot_of(head_reg, AW'(dst_reg));
    assign first_src_slot = slot_of(head_reg, AW'(first_src));
    assign next_src_slot  = slot_of(head_reg, AW'(next_src));
    assign head_inc       = slot_of(head_reg, AW'(1));

    assign sts.legal       = legal;
    assign sts.needs_fetch = (cmd_reg == CMD_POP) || (cmd_reg == CMD_READ)
                             || (cmd_reg == CMD_REMOVE);
    assign sts.is_remove   = (cmd_reg == CMD_REMOVE);
    assign sts.no_moves    = (moves_calc == '0);
    assign sts.last_move   = (moves_reg == CW'(1));

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tgt_slot;
        mem_wdata = wdata_reg;
        mem_re    = 1'b0;
        mem_raddr = tgt_slot;
        if (ctl.exec_write)
        begin
            mem_we = 1'b1;
        end
        if (ctl.shift_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = dst_slot;
            mem_wdata = rd_data_reg;
        end
        if (ctl.exec_fetch)
        begin
            mem_re = 1'b1;
        end
        if (ctl.fetch_done && (cmd_reg == CMD_REMOVE) && (moves_calc != '0))
        begin
            mem_re    = 1'b1;
            mem_raddr = first_src_slot;
        end
        if (ctl.shift_step && (moves_reg > CW'(1)))
        begin
            mem_re    = 1'b1;
            mem_raddr = next_src_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    // head and count
    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (ctl.exec_write && (cmd_reg == CMD_PUSH))
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (ctl.fetch_done)
        begin
            if (cmd_reg == CMD_POP)
            begin
                cnt_next  = n_after;
                head_next = head_inc;
            end
            else if (cmd_reg == CMD_REMOVE)
            begin
                cnt_next = n_after;
                if (!fwd_calc && (moves_calc == '0))
                begin
                    head_next = head_inc;
                end
            end
        end
        if (ctl.shift_step && (moves_reg == CW'(1)) && !fwd_reg)
        begin
            head_next = head_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd_t'(cmd);
            idx_reg   <= index;
            wdata_reg <= wdata_in;
        end
        if (ctl.exec_write)
        begin
            res_ok_reg   <= 1'b1;
            res_data_reg <= '0;
        end
        if (ctl.reject)
        begin
            res_ok_reg   <= 1'b0;
            res_data_reg <= '0;
        end
        if (ctl.fetch_done)
        begin
            res_ok_reg   <= 1'b1;
            res_data_reg <= rd_data_reg;
            if (cmd_reg == CMD_REMOVE)
            begin
                fwd_reg   <= fwd_calc;
                moves_reg <= moves_calc;
                dst_reg   <= idx_c;
            end
        end
        if (ctl.shift_step)
        begin
            dst_reg   <= fwd_reg ? (dst_reg + CW'(1)) : (dst_reg - CW'(1));
            moves_reg <= moves_reg - CW'(1);
        end
        if (ctl.load_out)
        begin
            ok_reg        <= res_ok_reg;
            read_data_reg <= rdata_word;
            count_reg     <= count_word;
        end
    end

    assign ok        = ok_reg;
    assign read_data = read_data_reg;
    assign count     = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_shift_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_step |-> moves_reg != '0)
        else $error("shift step with no move left");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec_write && (cmd_reg == CMD_PUSH)) |-> cnt_reg < DEPTH_C)
        else $error("push into a full store");
`endif

endmodule

// ===== hw/rtl/iqr_ctrl.sv =====
// Command sequencer: accept, execute, fetch, shift, deliver result.
module iqr_ctrl
    import iqr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  iqr_sts_t sts,
    output iqr_ctl_t ctl
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   rsp_free;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.legal)
                begin
                    ctl.reject = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.needs_fetch)
                begin
                    ctl.exec_fetch = 1'b1;
                    state_next     = ST_FETCH;
                end
                else
                begin
                    ctl.exec_write = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_FETCH:
            begin
                ctl.fetch_done = 1'b1;
                state_next     = (sts.is_remove && !sts.no_moves) ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (sts.last_move)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (ctl.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> state_reg == ST_EXEC)
        else $error("accepted transfer not executed");

    a_shift_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |->
            ($past(state_reg) == ST_FETCH || $past(state_reg) == ST_SHIFT))
        else $error("shift entered without a fetch");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result overwrote an untaken transfer");
`endif

endmodule
